// File: hw/rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and command frames of the SD card SPI sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  localparam int INIT_BYTES_DEF = 76;

  // Sequencer phase codes
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_INIT = 4'd1;
  localparam logic [3:0] PH_C0   = 4'd2;
  localparam logic [3:0] PH_C8   = 4'd3;
  localparam logic [3:0] PH_C55  = 4'd4;
  localparam logic [3:0] PH_C41  = 4'd5;
  localparam logic [3:0] PH_C17  = 4'd6;
  localparam logic [3:0] PH_POLL = 4'd7;
  localparam logic [3:0] PH_DATA = 4'd8;
  localparam logic [3:0] PH_DONE = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_READ_LENGTH   = 2'd1;

  localparam logic [12:0] READ_LENGTH_RST = 13'd512;

  // Input item kinds
  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_EXCHANGE = 1'b1;

  // Command frame layout: six command bytes, then response bytes
  localparam logic [3:0] CMD_LEN    = 4'd6;
  localparam logic [3:0] RSP_BYTE1  = 4'd7;   // second response byte
  localparam logic [3:0] RSP_BYTE4  = 4'd10;
  localparam logic [3:0] RSP_BYTE5  = 4'd11;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] CMD17_HEAD = 8'h51;
  localparam logic [7:0] CMD17_CRC  = 8'h01;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] CHK_PATTERN = 8'hAA;

  // Command frames, byte 0 in the lowest bits
  localparam logic [47:0] FRAME_CMD0  = 48'h95_00_00_00_00_40;
  localparam logic [47:0] FRAME_CMD8  = 48'h87_AA_01_00_00_48;
  localparam logic [47:0] FRAME_CMD55 = 48'h65_00_00_00_00_77;
  localparam logic [47:0] FRAME_CMD41 = 48'h77_00_00_00_40_69;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       send_next;
    logic       deselect;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       cmd8_fault;
    logic       done_res;
  } result_t;

  // Frame length of a command phase, including its response bytes where it has them (CMD17 has none)
  function automatic logic [3:0] frame_total(input logic [3:0] ph);
    logic [3:0] n;
    unique case (ph)
      PH_C0:   n = 4'd9;
      PH_C8:   n = 4'd13;
      PH_C55:  n = 4'd9;
      PH_C41:  n = 4'd9;
      PH_C17:  n = 4'd6;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // Byte sent at position idx of a command phase; response slots send 0xFF
  function automatic logic [7:0] cmd_byte(input logic [3:0]  ph,
                                          input logic [3:0]  idx,
                                          input logic [31:0] addr);
    logic [47:0] frame;
    logic [5:0]  sel;
    unique case (ph)
      PH_C0:   frame = FRAME_CMD0;
      PH_C8:   frame = FRAME_CMD8;
      PH_C55:  frame = FRAME_CMD55;
      PH_C41:  frame = FRAME_CMD41;
      PH_C17:  frame = {CMD17_CRC, addr[7:0], addr[15:8], addr[23:16], addr[31:24],
                        CMD17_HEAD};
      default: frame = {6{BYTE_IDLE}};
    endcase
    sel = {idx[2:0], 3'b000};
    if (idx >= CMD_LEN) begin
      return BYTE_IDLE;
    end
    return frame[sel +: 8];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sdspi_in_stage.sv
// ----------------------------------------------------------------------------
// sdspi_in_stage
// Input register of the sequencer: captures one transfer per cycle while it is empty or its held item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_in_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sdspi_pkg::item_t    in_item,
  input  wire                 adv,
  output logic                item_valid,
  output sdspi_pkg::item_t    item
);

  logic             vld_r, vld_nxt;
  sdspi_pkg::item_t item_r;

  // Accept while empty or while the held item moves on this cycle
  assign in_ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/sdspi_seq.sv
// ----------------------------------------------------------------------------
// sdspi_seq
// Sequencer state and next-byte decision for one completed exchange.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_seq #(
  parameter int INIT_BYTES = sdspi_pkg::INIT_BYTES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  adv,
  input  sdspi_pkg::item_t     item,
  input  wire  [31:0]          start_address,
  input  wire  [12:0]          read_length,
  output sdspi_pkg::result_t   res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic        chk_r, chk_nxt;
  logic        fault_r, fault_nxt;
  logic        fin_r, fin_nxt;
  logic [13:0] pos_inc;
  logic [7:0]  rx;
  logic        data_valid, data_last;
  logic [7:0]  data_byte;

  assign pos_inc = {1'b0, pos_r} + 14'd1;
  assign rx      = item.rx_byte;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    chk_nxt    = chk_r;
    fault_nxt  = fault_r;
    fin_nxt    = fin_r;
    data_byte  = 8'h00;
    data_valid = 1'b0;
    data_last  = 1'b0;
    if (item.kind == sdspi_pkg::KIND_START) begin
      phase_nxt = sdspi_pkg::PH_INIT;
      pos_nxt   = 13'd0;
      chk_nxt   = 1'b0;
      fault_nxt = 1'b0;
      fin_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        sdspi_pkg::PH_INIT: begin
          if (pos_inc >= 14'(INIT_BYTES)) begin
            phase_nxt = sdspi_pkg::PH_C0;
            pos_nxt   = 13'd0;
          end else begin
            pos_nxt = pos_inc[12:0];
          end
        end
        sdspi_pkg::PH_C0, sdspi_pkg::PH_C8, sdspi_pkg::PH_C55, sdspi_pkg::PH_C41,
        sdspi_pkg::PH_C17: begin
          if (phase_r == sdspi_pkg::PH_C0 && pos_r == 13'(sdspi_pkg::RSP_BYTE1)) begin
            chk_nxt = (rx == sdspi_pkg::R1_IDLE);
          end
          if (phase_r == sdspi_pkg::PH_C41 && pos_r == 13'(sdspi_pkg::RSP_BYTE1)) begin
            chk_nxt = (rx == sdspi_pkg::R1_READY);
          end
          // Interface condition echo: any mismatch latches the fault
          if (phase_r == sdspi_pkg::PH_C8) begin
            if ((pos_r == 13'(sdspi_pkg::RSP_BYTE1) && rx != sdspi_pkg::R1_IDLE) ||
                (pos_r == 13'(sdspi_pkg::RSP_BYTE4) && rx != sdspi_pkg::R1_IDLE) ||
                (pos_r == 13'(sdspi_pkg::RSP_BYTE5) && rx != sdspi_pkg::CHK_PATTERN)) begin
              fault_nxt = 1'b1;
            end
          end
          if (pos_inc < 14'(sdspi_pkg::frame_total(phase_r))) begin
            pos_nxt = pos_inc[12:0];
          end else begin
            pos_nxt = 13'd0;
            unique case (phase_r)
              sdspi_pkg::PH_C0:  phase_nxt = chk_nxt ? sdspi_pkg::PH_C8 : sdspi_pkg::PH_C0;
              sdspi_pkg::PH_C8:  phase_nxt = sdspi_pkg::PH_C55;
              sdspi_pkg::PH_C55: phase_nxt = sdspi_pkg::PH_C41;
              sdspi_pkg::PH_C41: phase_nxt = chk_nxt ? sdspi_pkg::PH_C17 : sdspi_pkg::PH_C55;
              default:           phase_nxt = sdspi_pkg::PH_POLL;
            endcase
          end
        end
        sdspi_pkg::PH_POLL: begin
          if (rx == sdspi_pkg::TOKEN_DATA) begin
            pos_nxt = 13'd0;
            if (read_length == 13'd0) begin
              phase_nxt = sdspi_pkg::PH_DONE;
              fin_nxt   = 1'b1;
            end else begin
              phase_nxt = sdspi_pkg::PH_DATA;
            end
          end
        end
        sdspi_pkg::PH_DATA: begin
          data_byte  = rx;
          data_valid = 1'b1;
          if (pos_inc >= {1'b0, read_length}) begin
            data_last = 1'b1;
            phase_nxt = sdspi_pkg::PH_DONE;
            pos_nxt   = 13'd0;
            fin_nxt   = 1'b1;
          end else begin
            pos_nxt = pos_inc[12:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Byte to issue next, from the updated phase and position
  always_comb begin
    unique case (phase_nxt)
      sdspi_pkg::PH_INIT: begin
        res.tx_byte   = sdspi_pkg::BYTE_IDLE;
        res.send_next = 1'b1;
        res.deselect  = 1'b1;
      end
      sdspi_pkg::PH_C0, sdspi_pkg::PH_C8, sdspi_pkg::PH_C55, sdspi_pkg::PH_C41,
      sdspi_pkg::PH_C17: begin
        res.tx_byte   = sdspi_pkg::cmd_byte(phase_nxt, pos_nxt[3:0], start_address);
        res.send_next = 1'b1;
        res.deselect  = 1'b0;
      end
      sdspi_pkg::PH_POLL, sdspi_pkg::PH_DATA: begin
        res.tx_byte   = sdspi_pkg::BYTE_IDLE;
        res.send_next = 1'b1;
        res.deselect  = 1'b0;
      end
      default: begin
        res.tx_byte   = sdspi_pkg::BYTE_IDLE;
        res.send_next = 1'b0;
        res.deselect  = 1'b1;
      end
    endcase
    res.data_byte  = data_byte;
    res.data_valid = data_valid;
    res.data_last  = data_last;
    res.cmd8_fault = fault_nxt;
    res.done_res   = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE;
      pos_r   <= 13'd0;
      chk_r   <= 1'b0;
      fault_r <= 1'b0;
      fin_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      chk_r   <= chk_nxt;
      fault_r <= fault_nxt;
      fin_r   <= fin_nxt;
    end
  end

  a_fin_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> phase_r == sdspi_pkg::PH_DONE)
    else $error("finished flag set outside the done phase");

  a_last_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.data_last |-> res.data_valid && res.done_res)
    else $error("last data byte without data or completion");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !res.send_next |-> res.tx_byte == sdspi_pkg::BYTE_IDLE && res.deselect)
    else $error("idle result carries a live byte or select");

  a_data_fires_once: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.data_last |=> !(phase_r == sdspi_pkg::PH_DATA))
    else $error("data phase continued past the last byte");

endmodule

`default_nettype wire

// File: hw/rtl/sdspi_out_stage.sv
// ----------------------------------------------------------------------------
// sdspi_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  item_valid,
  output logic                 adv,
  input  sdspi_pkg::result_t   res,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sdspi_pkg::result_t   out_res
);

  logic               vld_r, vld_nxt;
  sdspi_pkg::result_t res_r;

  // Move an item forward when the result slot is free or being drained
  assign adv = item_valid && (!vld_r || out_ready);

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// File: hw/rtl/sd_spi_init_block_read_sequencer.sv
// ----------------------------------------------------------------------------
// sd_spi_init_block_read_sequencer
// SD card SPI-mode bring-up and single block read, master-side sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in_      | in        | in_tvalid/in_tready  | tuser kind, tdata rx_byte
//  out_     | out       | out_tvalid/out_tready| tdata next byte + status,
//           |           |                      | tuser data_valid, tlast data_last
//  cfg_     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  Each transfer in passes an input register, one level of decision logic and
//  a result register; one transfer is taken per cycle while a result waiting
//  on out_tready does not hold the result register.
//  While a result waits on out_tready, the input register can still take one transfer.
//  rst_n is synchronous; it clears the phase, counters, flags and both stages
//  and loads start_address 0 and read_length 512.
//  Configuration writes are taken every cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_init_block_read_sequencer #(
  parameter int INIT_BYTES = sdspi_pkg::INIT_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // Exchange reports
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire         in_tuser,   // [0] kind
  // Next byte and block data
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [7:0] tx_byte, [8] send_next, [9] deselect,
                                  // [17:10] data_byte, [18] cmd8_fault,
                                  // [19] done_res, [23:20] zero
  output logic        out_tuser,  // [0] data_valid
  output logic        out_tlast,  // data_last
  // Register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  logic [31:0]        start_address_r;
  logic [12:0]        read_length_r;
  sdspi_pkg::item_t   in_item;
  sdspi_pkg::item_t   item;
  sdspi_pkg::result_t res;
  sdspi_pkg::result_t out_res;
  logic               item_valid;
  logic               adv;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= 32'd0;
      read_length_r   <= sdspi_pkg::READ_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == sdspi_pkg::CFG_START_ADDRESS) begin
        start_address_r <= cfg_data;
      end
      if (cfg_index == sdspi_pkg::CFG_READ_LENGTH) begin
        read_length_r <= cfg_data[12:0];
      end
    end
  end

  assign in_item.kind    = in_tuser;
  assign in_item.rx_byte = in_tdata;

  sdspi_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  sdspi_seq #(
    .INIT_BYTES (INIT_BYTES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .item          (item),
    .start_address (start_address_r),
    .read_length   (read_length_r),
    .res           (res)
  );

  sdspi_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .adv        (adv),
    .res        (res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Pack the result transfer
  assign out_tdata = {4'd0, out_res.done_res, out_res.cmd8_fault, out_res.data_byte,
                      out_res.deselect, out_res.send_next, out_res.tx_byte};
  assign out_tuser = out_res.data_valid;
  assign out_tlast = out_res.data_last;

endmodule

`default_nettype wire
